### rtl/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
// Used by mtep_core, mtep_out_stage and midi_track_event_parser; no dependencies.
package mtep_pkg;

  // varlen limits
  localparam int VARLEN_MAX_BYTES_DEF = 4;
  localparam int VARLEN_BITS          = 28;

  // parse phases
  localparam logic [3:0] PH_DELTA   = 4'd0;
  localparam logic [3:0] PH_STATUS  = 4'd1;
  localparam logic [3:0] PH_DATA1   = 4'd2;
  localparam logic [3:0] PH_DATA2   = 4'd3;
  localparam logic [3:0] PH_SYSLEN  = 4'd4;
  localparam logic [3:0] PH_SYSBODY = 4'd5;
  localparam logic [3:0] PH_MTYPE   = 4'd6;
  localparam logic [3:0] PH_MLEN    = 4'd7;
  localparam logic [3:0] PH_MBODY   = 4'd8;

  // event kinds
  localparam logic [2:0] KIND_CHANNEL   = 3'd0;
  localparam logic [2:0] KIND_SYSEX     = 3'd1;
  localparam logic [2:0] KIND_META      = 3'd2;
  localparam logic [2:0] KIND_END_TRACK = 3'd3;
  localparam logic [2:0] KIND_SYSTEM    = 3'd4;
  localparam logic [2:0] KIND_NO_STATUS = 3'd5;

  // status and meta codes
  localparam logic [7:0] ST_SYSEX_LAST = 8'hF7;
  localparam logic [7:0] ST_SYS_FIRST  = 8'hF0;
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] ST_ONE_DATA_LO = 8'hC0;
  localparam logic [7:0] ST_ONE_DATA_HI = 8'hDF;
  localparam logic [7:0] META_END_TRACK = 8'h2F;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_TIME_SIG  = 8'h58;

  // defaults
  localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
  localparam logic [7:0]  SIG_DEFAULT   = 8'd4;

  // one result item
  typedef struct packed {
    logic        event_valid;
    logic [2:0]  event_kind;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [27:0] delta_ticks;
    logic [27:0] payload_length;
    logic [23:0] tempo_us;
    logic [7:0]  sig_numerator;
    logic [7:0]  sig_denominator_log2;
  } event_t;

endpackage

### rtl/midi_track_event_parser.sv
// MIDI track event parser top level: ports, config register and wiring.
// Depends on mtep_pkg, mtep_core and mtep_out_stage.
//
// Usage:
//   in_*  : one track-chunk byte per request (in_valid/in_stall). Set
//           in_track_start on the first byte of each track.
//   out_* : one request per completed event (out_valid/out_stall); bytes
//           that complete no event produce nothing.
//   cfg_* : cfg_tempo_update_mode written when cfg_valid is high; cfg_ready
//           is always high. Write only while the parser is idle.
// Throughput: one byte per cycle while in_stall is low; the parse state
// updates in the cycle the byte is taken.
// Output: an event is written to the output register when its last byte
// is taken, or to the skid entry if the receiver stalls.
// Stall: the output register plus one skid entry absorb a stalled
// receiver; in_stall rises once the skid entry is occupied.
// Reset: rst_n (synchronous, low) clears the parse state, tempo (500000 us
// reported), time signature (numerator 4, denominator log2 4) and the config register.
module midi_track_event_parser #(
  parameter int VARLEN_MAX_BYTES = mtep_pkg::VARLEN_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_track_start,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_valid,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_status_byte,
  output logic [7:0]  out_first_data,
  output logic [7:0]  out_second_data,
  output logic [27:0] out_delta_ticks,
  output logic [27:0] out_payload_length,
  output logic [23:0] out_tempo_us,
  output logic [7:0]  out_sig_numerator,
  output logic [7:0]  out_sig_denominator_log2,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_tempo_update_mode
);

  logic             tempo_mode_r;
  logic             take;
  logic             res_valid;
  mtep_pkg::event_t res;
  mtep_pkg::event_t out_ev;
  logic             stage_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = stage_full;
  assign take      = in_valid && !stage_full;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      tempo_mode_r <= cfg_tempo_update_mode;
    end
  end

  mtep_core #(
    .VARLEN_MAX_BYTES (VARLEN_MAX_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .track_start (in_track_start),
    .data_byte   (in_data_byte),
    .tempo_mode  (tempo_mode_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  mtep_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (stage_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_ev)
  );

  // result fields
  assign out_event_valid          = out_ev.event_valid;
  assign out_event_kind           = out_ev.event_kind;
  assign out_status_byte          = out_ev.status_byte;
  assign out_first_data           = out_ev.first_data;
  assign out_second_data          = out_ev.second_data;
  assign out_delta_ticks          = out_ev.delta_ticks;
  assign out_payload_length       = out_ev.payload_length;
  assign out_tempo_us             = out_ev.tempo_us;
  assign out_sig_numerator        = out_ev.sig_numerator;
  assign out_sig_denominator_log2 = out_ev.sig_denominator_log2;

endmodule

### rtl/mtep_core.sv
// Parse state machine of the MIDI track event parser: one byte per request.
// Depends on mtep_pkg; produces a result item combinationally for the output stage.
module mtep_core #(
  parameter int VARLEN_MAX_BYTES = mtep_pkg::VARLEN_MAX_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic                track_start,
  input  logic [7:0]          data_byte,
  input  logic                tempo_mode,
  output logic                res_valid,
  output mtep_pkg::event_t    res
);

  localparam int CNT_W = $clog2(VARLEN_MAX_BYTES + 1);
  localparam int VB    = mtep_pkg::VARLEN_BITS;

  logic [3:0]     phase_r, phase_nxt;
  logic [VB-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]     running_r, running_nxt;
  logic [VB-1:0]  held_delta_r, held_delta_nxt;
  logic [7:0]     meta_type_r, meta_type_nxt;
  logic [VB-1:0]  remain_r, remain_nxt;
  logic [23:0]    head_r, head_nxt;
  logic [7:0]     held_first_r, held_first_nxt;
  logic [23:0]    tempo_r, tempo_nxt;
  logic [7:0]     num_r, num_nxt;
  logic [7:0]     den_r, den_nxt;
  logic           ended_r, ended_nxt;
  logic [7:0]     held_status_r, held_status_nxt;
  logic [VB-1:0]  held_len_r, held_len_nxt;

  logic [3:0]       eff_phase;
  logic [VB-1:0]    eff_acc;
  logic [CNT_W-1:0] eff_cnt;
  logic [7:0]       eff_running;
  logic             eff_ended;
  logic [VB-1:0]    vl_acc;
  logic [CNT_W-1:0] vl_cnt;
  logic             vl_done;
  logic [VB-1:0]    remain_dec;
  logic [VB-1:0]    body_idx;
  logic             emit;
  logic             do_meta;
  logic [2:0]       e_kind;
  logic [7:0]       e_status;
  logic [7:0]       e_d1;
  logic [7:0]       e_d2;
  logic [VB-1:0]    e_plen;

  // effective state after a track start clears it
  always_comb begin
    eff_phase   = track_start ? mtep_pkg::PH_DELTA : phase_r;
    eff_acc     = track_start ? '0 : acc_r;
    eff_cnt     = track_start ? '0 : cnt_r;
    eff_running = track_start ? 8'h00 : running_r;
    eff_ended   = track_start ? 1'b0 : ended_r;
  end

  // varlen shift step
  always_comb begin
    vl_acc     = {eff_acc[VB-8:0], data_byte[6:0]};
    vl_cnt     = eff_cnt + CNT_W'(1);
    vl_done    = !data_byte[7] || (vl_cnt >= CNT_W'(VARLEN_MAX_BYTES));
    remain_dec = remain_r - VB'(1);
    body_idx   = held_len_r - remain_r;
  end

  // next state and result
  always_comb begin
    phase_nxt       = eff_phase;
    acc_nxt         = eff_acc;
    cnt_nxt         = eff_cnt;
    running_nxt     = eff_running;
    held_delta_nxt  = held_delta_r;
    meta_type_nxt   = meta_type_r;
    remain_nxt      = remain_r;
    head_nxt        = head_r;
    held_first_nxt  = held_first_r;
    tempo_nxt       = tempo_r;
    num_nxt         = num_r;
    den_nxt         = den_r;
    ended_nxt       = eff_ended;
    held_status_nxt = held_status_r;
    held_len_nxt    = held_len_r;
    emit     = 1'b0;
    do_meta  = 1'b0;
    e_kind   = mtep_pkg::KIND_CHANNEL;
    e_status = 8'h00;
    e_d1     = 8'h00;
    e_d2     = 8'h00;
    e_plen   = '0;

    if (!eff_ended) begin
      unique case (eff_phase)
        mtep_pkg::PH_DELTA: begin
          acc_nxt = vl_done ? '0 : vl_acc;
          cnt_nxt = vl_done ? '0 : vl_cnt;
          if (vl_done) begin
            held_delta_nxt = vl_acc;
            phase_nxt      = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (data_byte[7]) begin
            held_status_nxt = data_byte;
            priority if (data_byte < mtep_pkg::ST_SYS_FIRST) begin
              running_nxt = data_byte;
              phase_nxt   = mtep_pkg::PH_DATA1;
            end else if (data_byte <= mtep_pkg::ST_SYSEX_LAST) begin
              running_nxt = 8'h00;
              phase_nxt   = mtep_pkg::PH_SYSLEN;
            end else if (data_byte == mtep_pkg::ST_META) begin
              running_nxt = 8'h00;
              phase_nxt   = mtep_pkg::PH_MTYPE;
            end else begin
              phase_nxt = mtep_pkg::PH_DELTA;
              emit      = 1'b1;
              e_kind    = mtep_pkg::KIND_SYSTEM;
              e_status  = data_byte;
            end
          end else if (eff_running == 8'h00) begin
            phase_nxt = mtep_pkg::PH_DELTA;
            emit      = 1'b1;
            e_kind    = mtep_pkg::KIND_NO_STATUS;
            e_d1      = data_byte;
          end else begin
            held_status_nxt = eff_running;
            if (eff_running >= mtep_pkg::ST_ONE_DATA_LO &&
                eff_running <= mtep_pkg::ST_ONE_DATA_HI) begin
              phase_nxt = mtep_pkg::PH_DELTA;
              emit      = 1'b1;
              e_status  = eff_running;
              e_d1      = data_byte;
            end else begin
              held_first_nxt = data_byte;
              phase_nxt      = mtep_pkg::PH_DATA2;
            end
          end
        end
        mtep_pkg::PH_DATA1: begin
          if (held_status_r >= mtep_pkg::ST_ONE_DATA_LO &&
              held_status_r <= mtep_pkg::ST_ONE_DATA_HI) begin
            phase_nxt = mtep_pkg::PH_DELTA;
            emit      = 1'b1;
            e_status  = held_status_r;
            e_d1      = data_byte;
          end else begin
            held_first_nxt = data_byte;
            phase_nxt      = mtep_pkg::PH_DATA2;
          end
        end
        mtep_pkg::PH_DATA2: begin
          phase_nxt = mtep_pkg::PH_DELTA;
          emit      = 1'b1;
          e_status  = held_status_r;
          e_d1      = held_first_r;
          e_d2      = data_byte;
        end
        mtep_pkg::PH_SYSLEN: begin
          acc_nxt = vl_done ? '0 : vl_acc;
          cnt_nxt = vl_done ? '0 : vl_cnt;
          if (vl_done) begin
            held_len_nxt = vl_acc;
            remain_nxt   = vl_acc;
            if (vl_acc == '0) begin
              phase_nxt = mtep_pkg::PH_DELTA;
              emit      = 1'b1;
              e_kind    = mtep_pkg::KIND_SYSEX;
              e_status  = held_status_r;
            end else begin
              phase_nxt = mtep_pkg::PH_SYSBODY;
            end
          end
        end
        mtep_pkg::PH_SYSBODY: begin
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            phase_nxt = mtep_pkg::PH_DELTA;
            emit      = 1'b1;
            e_kind    = mtep_pkg::KIND_SYSEX;
            e_status  = held_status_r;
            e_plen    = held_len_r;
          end
        end
        mtep_pkg::PH_MTYPE: begin
          meta_type_nxt = data_byte;
          head_nxt      = 24'h000000;
          phase_nxt     = mtep_pkg::PH_MLEN;
        end
        mtep_pkg::PH_MLEN: begin
          acc_nxt = vl_done ? '0 : vl_acc;
          cnt_nxt = vl_done ? '0 : vl_cnt;
          if (vl_done) begin
            held_len_nxt = vl_acc;
            remain_nxt   = vl_acc;
            if (vl_acc == '0) begin
              do_meta = 1'b1;
            end else begin
              phase_nxt = mtep_pkg::PH_MBODY;
            end
          end
        end
        mtep_pkg::PH_MBODY: begin
          // first three payload bytes land in the head, msb first
          if (body_idx[VB-1:2] == '0) begin
            unique case (body_idx[1:0])
              2'd0:    head_nxt = head_r | {data_byte, 16'h0000};
              2'd1:    head_nxt = head_r | {8'h00, data_byte, 8'h00};
              2'd2:    head_nxt = head_r | {16'h0000, data_byte};
              default: head_nxt = head_r;
            endcase
          end
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            do_meta = 1'b1;
          end
        end
        default: begin
          phase_nxt = mtep_pkg::PH_DELTA;
        end
      endcase

      // meta event completion
      if (do_meta) begin
        phase_nxt = mtep_pkg::PH_DELTA;
        emit      = 1'b1;
        e_status  = mtep_pkg::ST_META;
        e_d1      = meta_type_r;
        e_plen    = held_len_nxt;
        if (meta_type_r == mtep_pkg::META_END_TRACK) begin
          ended_nxt = 1'b1;
          e_kind    = mtep_pkg::KIND_END_TRACK;
        end else begin
          e_kind = mtep_pkg::KIND_META;
          if (meta_type_r == mtep_pkg::META_TIME_SIG) begin
            num_nxt = head_nxt[23:16];
            den_nxt = head_nxt[15:8];
          end else if (meta_type_r == mtep_pkg::META_TEMPO) begin
            if (tempo_mode || tempo_r == 24'h000000) begin
              tempo_nxt = head_nxt;
            end
          end
        end
      end
    end
  end

  // result item
  always_comb begin
    res_valid                = take && emit;
    res.event_valid          = 1'b1;
    res.event_kind           = e_kind;
    res.status_byte          = e_status;
    res.first_data           = e_d1;
    res.second_data          = e_d2;
    res.delta_ticks          = held_delta_nxt;
    res.payload_length       = e_plen;
    res.tempo_us             = (tempo_nxt == 24'h000000) ? mtep_pkg::TEMPO_DEFAULT : tempo_nxt;
    res.sig_numerator        = num_nxt;
    res.sig_denominator_log2 = den_nxt;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= mtep_pkg::PH_DELTA;
      acc_r         <= '0;
      cnt_r         <= '0;
      running_r     <= 8'h00;
      held_delta_r  <= '0;
      meta_type_r   <= 8'h00;
      remain_r      <= '0;
      head_r        <= 24'h000000;
      held_first_r  <= 8'h00;
      tempo_r       <= 24'h000000;
      num_r         <= mtep_pkg::SIG_DEFAULT;
      den_r         <= mtep_pkg::SIG_DEFAULT;
      ended_r       <= 1'b0;
      held_status_r <= 8'h00;
      held_len_r    <= '0;
    end else if (take) begin
      phase_r       <= phase_nxt;
      acc_r         <= acc_nxt;
      cnt_r         <= cnt_nxt;
      running_r     <= running_nxt;
      held_delta_r  <= held_delta_nxt;
      meta_type_r   <= meta_type_nxt;
      remain_r      <= remain_nxt;
      head_r        <= head_nxt;
      held_first_r  <= held_first_nxt;
      tempo_r       <= tempo_nxt;
      num_r         <= num_nxt;
      den_r         <= den_nxt;
      ended_r       <= ended_nxt;
      held_status_r <= held_status_nxt;
      held_len_r    <= held_len_nxt;
    end
  end

endmodule

### rtl/mtep_out_stage.sv
// Output register with a skid entry for the MIDI track event parser.
// Depends on mtep_pkg for the result item type.
module mtep_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mtep_pkg::event_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output mtep_pkg::event_t  out_data
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  mtep_pkg::event_t main_r;
  mtep_pkg::event_t skid_r;
  logic             main_free;

  assign main_free = !main_valid_r || !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // valid bookkeeping
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (main_free) begin
      main_valid_nxt = skid_valid_r || push;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload moves
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

### test/testbench.sv
// Self-checking testbench for midi_track_event_parser: directed and random track byte streams.
// Keeps its own model of the parser and checks every event field by field.
// Depends on mtep_pkg and the midi_track_event_parser RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VL_MAX = mtep_pkg::VARLEN_MAX_BYTES_DEF;
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_track_start;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_event_valid;
  logic [2:0]  out_event_kind;
  logic [7:0]  out_status_byte;
  logic [7:0]  out_first_data;
  logic [7:0]  out_second_data;
  logic [27:0] out_delta_ticks;
  logic [27:0] out_payload_length;
  logic [23:0] out_tempo_us;
  logic [7:0]  out_sig_numerator;
  logic [7:0]  out_sig_denominator_log2;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_tempo_update_mode;

  midi_track_event_parser dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_track_start           (in_track_start),
    .in_data_byte             (in_data_byte),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_event_valid          (out_event_valid),
    .out_event_kind           (out_event_kind),
    .out_status_byte          (out_status_byte),
    .out_first_data           (out_first_data),
    .out_second_data          (out_second_data),
    .out_delta_ticks          (out_delta_ticks),
    .out_payload_length       (out_payload_length),
    .out_tempo_us             (out_tempo_us),
    .out_sig_numerator        (out_sig_numerator),
    .out_sig_denominator_log2 (out_sig_denominator_log2),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_tempo_update_mode    (cfg_tempo_update_mode)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 error_count;
  int unsigned        bytes_parsed;
  mtep_pkg::event_t   expected_events[$];

  // parser model state
  logic [3:0]  phase;
  logic [27:0] vl_acc;
  logic [2:0]  vl_cnt;
  logic [7:0]  run_status;
  logic [27:0] delta_hold;
  logic [7:0]  mtype;
  logic [27:0] remaining;
  logic [23:0] head;
  logic [7:0]  first_hold;
  logic [23:0] tempo_kept;
  logic [7:0]  sig_num;
  logic [7:0]  sig_den;
  logic        ended;
  logic [7:0]  status_hold;
  logic [27:0] len_hold;
  logic        tempo_mode;

  task automatic clear_parser_model();
    phase = mtep_pkg::PH_DELTA;
    vl_acc = '0;
    vl_cnt = '0;
    run_status = '0;
    delta_hold = '0;
    mtype = '0;
    remaining = '0;
    head = '0;
    first_hold = '0;
    tempo_kept = '0;
    sig_num = mtep_pkg::SIG_DEFAULT;
    sig_den = mtep_pkg::SIG_DEFAULT;
    ended = 1'b0;
    status_hold = '0;
    len_hold = '0;
    tempo_mode = 1'b0;
  endtask

  // one varlen group; done when bit 7 is clear or the byte limit is hit
  task automatic shift_varlen(input logic [7:0] b, output bit done, output logic [27:0] val);
    vl_acc = {vl_acc[20:0], b[6:0]};
    vl_cnt = vl_cnt + 3'd1;
    done = !b[7] || (vl_cnt >= VL_MAX);
    val = vl_acc;
    if (done) begin
      vl_acc = '0;
      vl_cnt = '0;
    end
  endtask

  task automatic post_event(input logic [2:0] kind, input logic [7:0] st, input logic [7:0] d1,
                            input logic [7:0] d2, input logic [27:0] plen);
    mtep_pkg::event_t ev;
    ev.event_valid = 1'b1;
    ev.event_kind = kind;
    ev.status_byte = st;
    ev.first_data = d1;
    ev.second_data = d2;
    ev.delta_ticks = delta_hold;
    ev.payload_length = plen;
    ev.tempo_us = (tempo_kept == '0) ? mtep_pkg::TEMPO_DEFAULT : tempo_kept;
    ev.sig_numerator = sig_num;
    ev.sig_denominator_log2 = sig_den;
    expected_events.insert(expected_events.size(), ev);
  endtask

  // meta complete: update kept tempo / time signature, then report
  task automatic close_meta();
    phase = mtep_pkg::PH_DELTA;
    if (mtype == mtep_pkg::META_END_TRACK) begin
      ended = 1'b1;
      post_event(mtep_pkg::KIND_END_TRACK, mtep_pkg::ST_META, mtype, 8'h00, len_hold);
    end else begin
      if (mtype == mtep_pkg::META_TIME_SIG) begin
        sig_num = head[23:16];
        sig_den = head[15:8];
      end else if (mtype == mtep_pkg::META_TEMPO && (tempo_mode || tempo_kept == '0)) begin
        tempo_kept = head;
      end
      post_event(mtep_pkg::KIND_META, mtep_pkg::ST_META, mtype, 8'h00, len_hold);
    end
  endtask

  task automatic take_first_data(input logic [7:0] b);
    if (status_hold >= mtep_pkg::ST_ONE_DATA_LO && status_hold <= mtep_pkg::ST_ONE_DATA_HI) begin
      phase = mtep_pkg::PH_DELTA;
      post_event(mtep_pkg::KIND_CHANNEL, status_hold, b, 8'h00, '0);
    end else begin
      first_hold = b;
      phase = mtep_pkg::PH_DATA2;
    end
  endtask

  // advance the model by one accepted byte
  task automatic parse_track_byte(input logic ts, input logic [7:0] b);
    bit          done;
    logic [27:0] val;
    logic [27:0] idx;
    if (ts) begin
      run_status = '0;
      phase = mtep_pkg::PH_DELTA;
      vl_acc = '0;
      vl_cnt = '0;
      ended = 1'b0;
    end
    if (!ended) begin
      bytes_parsed++;
      case (phase)
        mtep_pkg::PH_DELTA: begin
          shift_varlen(b, done, val);
          if (done) begin
            delta_hold = val;
            phase = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (b[7]) begin
            status_hold = b;
            if (b < mtep_pkg::ST_SYS_FIRST) begin
              run_status = b;
              phase = mtep_pkg::PH_DATA1;
            end else if (b <= mtep_pkg::ST_SYSEX_LAST) begin
              run_status = '0;
              phase = mtep_pkg::PH_SYSLEN;
            end else if (b == mtep_pkg::ST_META) begin
              run_status = '0;
              phase = mtep_pkg::PH_MTYPE;
            end else begin
              phase = mtep_pkg::PH_DELTA;
              post_event(mtep_pkg::KIND_SYSTEM, b, 8'h00, 8'h00, '0);
            end
          end else if (run_status == '0) begin
            phase = mtep_pkg::PH_DELTA;
            post_event(mtep_pkg::KIND_NO_STATUS, 8'h00, b, 8'h00, '0);
          end else begin
            status_hold = run_status;
            take_first_data(b);
          end
        end
        mtep_pkg::PH_DATA1: take_first_data(b);
        mtep_pkg::PH_DATA2: begin
          phase = mtep_pkg::PH_DELTA;
          post_event(mtep_pkg::KIND_CHANNEL, status_hold, first_hold, b, '0);
        end
        mtep_pkg::PH_SYSLEN: begin
          shift_varlen(b, done, val);
          if (done) begin
            len_hold = val;
            remaining = val;
            if (val == '0) begin
              phase = mtep_pkg::PH_DELTA;
              post_event(mtep_pkg::KIND_SYSEX, status_hold, 8'h00, 8'h00, '0);
            end else begin
              phase = mtep_pkg::PH_SYSBODY;
            end
          end
        end
        mtep_pkg::PH_SYSBODY: begin
          remaining = remaining - 28'd1;
          if (remaining == '0) begin
            phase = mtep_pkg::PH_DELTA;
            post_event(mtep_pkg::KIND_SYSEX, status_hold, 8'h00, 8'h00, len_hold);
          end
        end
        mtep_pkg::PH_MTYPE: begin
          mtype = b;
          head = '0;
          phase = mtep_pkg::PH_MLEN;
        end
        mtep_pkg::PH_MLEN: begin
          shift_varlen(b, done, val);
          if (done) begin
            len_hold = val;
            remaining = val;
            if (val == '0) close_meta();
            else phase = mtep_pkg::PH_MBODY;
          end
        end
        mtep_pkg::PH_MBODY: begin
          // only the first three payload bytes are kept
          idx = len_hold - remaining;
          if (idx == 28'd0) head[23:16] = head[23:16] | b;
          else if (idx == 28'd1) head[15:8] = head[15:8] | b;
          else if (idx == 28'd2) head[7:0] = head[7:0] | b;
          remaining = remaining - 28'd1;
          if (remaining == '0) close_meta();
        end
        default: phase = mtep_pkg::PH_DELTA;
      endcase
    end
  endtask

  // one byte request; entered and left at a falling edge
  task automatic send_byte(input logic ts, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_track_start <= ts;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    parse_track_byte(ts, b);
    @(negedge clk);
  endtask

  // wait until every expected event is out, plus the output latency
  task automatic settle_parser();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_tempo_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_tempo_update_mode <= m;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    tempo_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] data_value();
    // mostly plain data, now and then a byte with bit 7 set
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic send_delta(input logic ts);
    int   n;
    int   pick;
    logic cont;
    pick = $urandom_range(0, 99);
    n = (pick < 70) ? 1 : (pick < 85) ? 2 : (pick < 95) ? 3 : 4;
    for (int i = 0; i < n; i++) begin
      // a four-byte delta may keep bit 7 set on its last byte
      cont = (i < n - 1) || (n == 4 && $urandom_range(0, 1) == 1);
      send_byte((i == 0) ? ts : 1'b0, {cont, 7'($urandom)});
    end
  endtask

  task automatic send_length(input int unsigned len);
    logic [13:0] lv;
    lv = 14'(len);
    if (lv >= 14'd128) send_byte(1'b0, {1'b1, lv[13:7]});
    else if ($urandom_range(0, 7) == 0) send_byte(1'b0, 8'h80);
    send_byte(1'b0, {1'b0, lv[6:0]});
  endtask

  // one random event, mostly well formed
  task automatic send_random_event();
    int          pick;
    int          pick2;
    int          n;
    int unsigned len;
    logic [7:0]  st;
    logic [7:0]  mt;
    logic        zero_body;
    pick = $urandom_range(0, 99);
    if (pick >= 92) begin
      // noise: loose bytes, now and then a track start
      n = $urandom_range(1, 3);
      repeat (n) send_byte($urandom_range(0, 3) == 0, 8'($urandom));
    end else begin
      send_delta(ended || $urandom_range(0, 99) < 5);
      if (pick < 30) begin
        // channel message with its status
        st = 8'($urandom_range(8'h80, 8'hEF));
        send_byte(1'b0, st);
        send_byte(1'b0, data_value());
        if (!(st >= mtep_pkg::ST_ONE_DATA_LO && st <= mtep_pkg::ST_ONE_DATA_HI))
          send_byte(1'b0, data_value());
      end else if (pick < 45) begin
        // running status, or a missing one
        st = run_status;
        send_byte(1'b0, 8'($urandom_range(0, 127)));
        if (st != 8'h00 &&
            !(st >= mtep_pkg::ST_ONE_DATA_LO && st <= mtep_pkg::ST_ONE_DATA_HI))
          send_byte(1'b0, data_value());
      end else if (pick < 51) begin
        send_byte(1'b0, 8'($urandom_range(8'hF8, 8'hFE)));
      end else if (pick < 61) begin
        // sysex with a skipped payload
        pick2 = $urandom_range(0, 99);
        len = (pick2 < 70) ? $urandom_range(0, 6) :
              (pick2 < 96) ? $urandom_range(7, 20) : $urandom_range(120, 135);
        send_byte(1'b0, 8'($urandom_range(mtep_pkg::ST_SYS_FIRST, mtep_pkg::ST_SYSEX_LAST)));
        send_length(len);
        repeat (len) send_byte(1'b0, 8'($urandom));
      end else if (pick < 87) begin
        // meta: tempo, time signature or any type
        pick2 = $urandom_range(0, 99);
        if (pick2 < 35) begin
          mt = mtep_pkg::META_TEMPO;
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 3;
        end else if (pick2 < 60) begin
          mt = mtep_pkg::META_TIME_SIG;
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 4;
        end else begin
          mt = 8'($urandom);
          len = $urandom_range(0, 8);
        end
        zero_body = ($urandom_range(0, 9) == 0);
        send_byte(1'b0, mtep_pkg::ST_META);
        send_byte(1'b0, mt);
        send_length(len);
        repeat (len) send_byte(1'b0, zero_body ? 8'h00 : 8'($urandom));
      end else begin
        send_byte(1'b0, mtep_pkg::ST_META);
        send_byte(1'b0, mtep_pkg::META_END_TRACK);
        send_byte(1'b0, 8'h00);
      end
    end
  endtask

  // hand-picked track covering each event kind and the corner cases
  task automatic test_directed_events();
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'h3C);   // data with no running status
    repeat (4) send_byte(1'b0, 8'hFF);  // delta cut off at four bytes
    send_byte(1'b0, 8'h90);
    send_byte(1'b0, 8'h80);   // bit 7 set inside a channel message
    send_byte(1'b0, 8'h7F);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h40);   // running status
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hF8);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hF7);   // empty sysex
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, mtep_pkg::ST_META);
    send_byte(1'b0, mtep_pkg::META_TEMPO);
    send_byte(1'b0, 8'h02);   // tempo payload one byte short
    send_byte(1'b0, 8'h07);
    send_byte(1'b0, 8'hA1);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, mtep_pkg::ST_META);
    send_byte(1'b0, mtep_pkg::META_END_TRACK);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h55);   // ignored after end of track
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'hC5);
    send_byte(1'b0, 8'h7F);
  endtask

  task automatic test_random_stream(input int n_bytes, input int idle_pct, input int stall_pct,
                                    input logic mode);
    int unsigned goal;
    settle_parser();
    write_tempo_mode(mode);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    goal = bytes_parsed + n_bytes;
    while (bytes_parsed < goal) send_random_event();
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [27:0] got, input logic [27:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // receiver stall, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // check each delivered event against the oldest expected one
  always @(posedge clk) begin : result_check
    mtep_pkg::event_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d status %h",
                                  out_event_kind, out_status_byte));
      end else begin
        want = expected_events.pop_front();
        compare_field("event_valid", 28'(out_event_valid), 28'(want.event_valid));
        compare_field("event_kind", 28'(out_event_kind), 28'(want.event_kind));
        compare_field("status_byte", 28'(out_status_byte), 28'(want.status_byte));
        compare_field("first_data", 28'(out_first_data), 28'(want.first_data));
        compare_field("second_data", 28'(out_second_data), 28'(want.second_data));
        compare_field("delta_ticks", out_delta_ticks, want.delta_ticks);
        compare_field("payload_length", out_payload_length, want.payload_length);
        compare_field("tempo_us", 28'(out_tempo_us), 28'(want.tempo_us));
        compare_field("sig_numerator", 28'(out_sig_numerator), 28'(want.sig_numerator));
        compare_field("sig_denominator_log2", 28'(out_sig_denominator_log2),
                      28'(want.sig_denominator_log2));
      end
    end
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_track_start = 1'b0;
    in_data_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_tempo_update_mode = 1'b0;
    out_stall = 1'b0;
    error_count = 0;
    bytes_parsed = 0;
    send_idle_pct = 25;
    recv_stall_pct = 72;
    clear_parser_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_events();
    test_random_stream(460, 25, 72, 1'b1);
    test_random_stream(460, 72, 25, 1'b0);
    test_random_stream(460, 0, 0, 1'b1);
    settle_parser();
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

### files.f
rtl/mtep_pkg.sv
rtl/mtep_core.sv
rtl/mtep_out_stage.sv
rtl/midi_track_event_parser.sv
test/testbench.sv
